// ===== rtl/mme_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mme_pkg
// shared types and constants for the matrix multiply engine
// ---------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM   = 8;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = 35;
  localparam int DIMREG_W  = 4;
  localparam int CFGIDX_W  = 3;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_DIMS = 2'd2;

  localparam logic [CFGIDX_W-1:0] REG_A_ROWS = 3'd0;
  localparam logic [CFGIDX_W-1:0] REG_A_COLS = 3'd1;
  localparam logic [CFGIDX_W-1:0] REG_B_ROWS = 3'd2;
  localparam logic [CFGIDX_W-1:0] REG_B_COLS = 3'd3;
  localparam logic [CFGIDX_W-1:0] REG_C_ROWS = 3'd4;
  localparam logic [CFGIDX_W-1:0] REG_C_COLS = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  // control that travels with each read pair through the datapath
  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  function automatic logic dim_ok(input logic [DIMREG_W-1:0] d);
    dim_ok = (d != '0) && (d <= DIMREG_W'(MAX_DIM));
  endfunction

endpackage

// ===== rtl/mme_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mme_ram
// element store, one write port and one registered read port
// ---------------------------------------------------------------------------
module mme_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [mme_pkg::ADDR_W-1:0]        waddr,
  input  logic signed [mme_pkg::ELEM_W-1:0] wdata,
  input  logic [mme_pkg::ADDR_W-1:0]        raddr,
  output logic signed [mme_pkg::ELEM_W-1:0] rdata
);

  logic signed [mme_pkg::ELEM_W-1:0] mem [mme_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mme_mac.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mme_mac
// multiply stage then accumulate stage; emits a sum on the last term
// ---------------------------------------------------------------------------
module mme_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  mme_pkg::tag_t                     in_tag,
  input  logic signed [mme_pkg::ELEM_W-1:0] a_data,
  input  logic signed [mme_pkg::ELEM_W-1:0] b_data,
  output logic                              res_vld,
  output mme_pkg::tag_t                     res_tag,
  output logic signed [mme_pkg::SUM_W-1:0]  res_sum
);

  logic                              mul_vld_r;
  mme_pkg::tag_t                     mul_tag_r;
  logic signed [mme_pkg::PROD_W-1:0] prod_r;

  logic                              acc_vld_r, acc_vld_nxt;
  mme_pkg::tag_t                     acc_tag_r;
  logic signed [mme_pkg::SUM_W-1:0]  acc_r, acc_nxt;
  logic signed [mme_pkg::SUM_W-1:0]  prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    mul_tag_r <= in_tag;
    prod_r    <= a_data * b_data;
  end

  assign prod_ext    = mme_pkg::SUM_W'(prod_r);
  assign acc_nxt     = mul_tag_r.first ? prod_ext : acc_r + prod_ext;
  assign acc_vld_nxt = mul_vld_r && mul_tag_r.last_k;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= acc_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_vld_r) begin
      acc_r     <= acc_nxt;
      acc_tag_r <= mul_tag_r;
    end
  end

  assign res_vld = acc_vld_r;
  assign res_tag = acc_tag_r;
  assign res_sum = acc_r;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_multiply_engine
// fixed point dense matrix multiply over two 8x8 element stores
// ---------------------------------------------------------------------------
// Loads never raise busy, so a load word can be issued every cycle while
// busy is low. A compute word whose dimensions fail the checks gives its
// single error word on out_valid in the cycle after acceptance. A good
// compute holds busy high until its final word is on out_valid: one pair
// of store reads per cycle feeds a single multiply-accumulate pipeline,
// and the C elements come out in row-major order, each once the last of
// its a_cols terms is summed. Each result word is valid for exactly one
// cycle and cannot be held off.
module matrix_multiply_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 cfg_we,
  input  logic [mme_pkg::CFGIDX_W-1:0]         cfg_index,
  input  logic [mme_pkg::DIMREG_W-1:0]         cfg_data,

  input  logic                                 start,
  output logic                                 busy,
  input  logic [mme_pkg::CMD_W-1:0]            in_command,
  input  logic [mme_pkg::IDX_W-1:0]            in_row_index,
  input  logic [mme_pkg::IDX_W-1:0]            in_col_index,
  input  logic signed [mme_pkg::ELEM_W-1:0]    in_element,

  output logic                                 out_valid,
  output logic [mme_pkg::STAT_W-1:0]           out_status,
  output logic [mme_pkg::IDX_W-1:0]            out_row,
  output logic [mme_pkg::IDX_W-1:0]            out_col,
  output logic signed [mme_pkg::SUM_W-1:0]     out_product,
  output logic                                 out_last
);

  logic [mme_pkg::DIMREG_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r, c_rows_r, c_cols_r;

  mme_pkg::state_t state_r, state_nxt;
  logic [mme_pkg::IDX_W-1:0] i_r, j_r, k_r;
  logic [mme_pkg::IDX_W-1:0] i_nxt, j_nxt, k_nxt;

  logic accept, do_compute, dims_invalid, dims_bad, dims_err, issue;
  logic last_i, last_j, last_k;
  logic we_a, we_b;

  logic                              iss_v_r;
  mme_pkg::tag_t                     iss_tag_r, iss_tag;
  logic signed [mme_pkg::ELEM_W-1:0] a_rd, b_rd;

  logic                              mac_vld;
  mme_pkg::tag_t                     mac_tag;
  logic signed [mme_pkg::SUM_W-1:0]  mac_sum;

  logic                              out_valid_r, out_valid_nxt;
  logic [mme_pkg::STAT_W-1:0]        out_status_r;
  logic [mme_pkg::IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [mme_pkg::SUM_W-1:0]  out_product_r;
  logic                              out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= mme_pkg::DIMREG_W'(1);
      a_cols_r <= mme_pkg::DIMREG_W'(1);
      b_rows_r <= mme_pkg::DIMREG_W'(1);
      b_cols_r <= mme_pkg::DIMREG_W'(1);
      c_rows_r <= mme_pkg::DIMREG_W'(1);
      c_cols_r <= mme_pkg::DIMREG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mme_pkg::REG_A_ROWS: a_rows_r <= cfg_data;
        mme_pkg::REG_A_COLS: a_cols_r <= cfg_data;
        mme_pkg::REG_B_ROWS: b_rows_r <= cfg_data;
        mme_pkg::REG_B_COLS: b_cols_r <= cfg_data;
        mme_pkg::REG_C_ROWS: c_rows_r <= cfg_data;
        mme_pkg::REG_C_COLS: c_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept     = start && !busy;
  assign do_compute = accept && (in_command == mme_pkg::CMD_COMPUTE);
  assign we_a       = accept && (in_command == mme_pkg::CMD_LOAD_A);
  assign we_b       = accept && (in_command == mme_pkg::CMD_LOAD_B);

  assign dims_invalid = !mme_pkg::dim_ok(a_rows_r) || !mme_pkg::dim_ok(a_cols_r) ||
                        !mme_pkg::dim_ok(b_rows_r) || !mme_pkg::dim_ok(b_cols_r) ||
                        !mme_pkg::dim_ok(c_rows_r) || !mme_pkg::dim_ok(c_cols_r);
  assign dims_bad     = (a_cols_r != b_rows_r) || (c_rows_r != a_rows_r) ||
                        (c_cols_r != b_cols_r);
  assign dims_err     = dims_invalid || dims_bad;

  assign last_k = ({1'b0, k_r} == a_cols_r - mme_pkg::DIMREG_W'(1));
  assign last_j = ({1'b0, j_r} == b_cols_r - mme_pkg::DIMREG_W'(1));
  assign last_i = ({1'b0, i_r} == a_rows_r - mme_pkg::DIMREG_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mme_pkg::S_IDLE: begin
        if (do_compute && !dims_err) begin
          state_nxt = mme_pkg::S_RUN;
        end
      end
      mme_pkg::S_RUN: begin
        if (last_i && last_j && last_k) begin
          state_nxt = mme_pkg::S_DRAIN;
        end
      end
      mme_pkg::S_DRAIN: begin
        if (mac_vld && mac_tag.last_elem) begin
          state_nxt = mme_pkg::S_IDLE;
        end
      end
      default: state_nxt = mme_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy  = 1'b0;
    issue = 1'b0;
    case (state_r)
      mme_pkg::S_IDLE:  busy = 1'b0;
      mme_pkg::S_RUN: begin
        busy  = 1'b1;
        issue = 1'b1;
      end
      mme_pkg::S_DRAIN: busy = 1'b1;
      default:          busy = 1'b0;
    endcase
  end

  // k innermost, then j, then i
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (!issue) begin
      i_nxt = '0;
      j_nxt = '0;
      k_nxt = '0;
    end else if (!last_k) begin
      k_nxt = k_r + 1'b1;
    end else begin
      k_nxt = '0;
      if (!last_j) begin
        j_nxt = j_r + 1'b1;
      end else begin
        j_nxt = '0;
        i_nxt = i_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      iss_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      iss_v_r <= issue;
    end
  end

  always_comb begin
    iss_tag.first     = (k_r == '0);
    iss_tag.last_k    = last_k;
    iss_tag.last_elem = last_i && last_j;
    iss_tag.row       = i_r;
    iss_tag.col       = j_r;
  end

  // tag lines up with the registered read data
  always_ff @(posedge clk) begin
    iss_tag_r <= iss_tag;
  end

  mme_ram u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr ({in_row_index, in_col_index}),
    .wdata (in_element),
    .raddr ({i_r, k_r}),
    .rdata (a_rd)
  );

  mme_ram u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr ({in_row_index, in_col_index}),
    .wdata (in_element),
    .raddr ({k_r, j_r}),
    .rdata (b_rd)
  );

  mme_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (iss_v_r),
    .in_tag  (iss_tag_r),
    .a_data  (a_rd),
    .b_data  (b_rd),
    .res_vld (mac_vld),
    .res_tag (mac_tag),
    .res_sum (mac_sum)
  );

  // output word register: mac result, else error word straight from accept
  assign out_valid_nxt = (do_compute && dims_err) || mac_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_vld) begin
      out_status_r  <= mme_pkg::ST_OK;
      out_row_r     <= mac_tag.row;
      out_col_r     <= mac_tag.col;
      out_product_r <= mac_sum;
      out_last_r    <= mac_tag.last_elem;
    end else if (do_compute && dims_err) begin
      out_status_r  <= dims_invalid ? mme_pkg::ST_INVALID : mme_pkg::ST_BAD_DIMS;
      out_row_r     <= '0;
      out_col_r     <= '0;
      out_product_r <= '0;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_product = out_product_r;
  assign out_last    = out_last_r;

  // error words are always single and final
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != mme_pkg::ST_OK) |-> out_last)
    else $error("error word without last");

  // nothing left in flight once the sequencer is back to idle
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mme_pkg::S_IDLE) |-> (!iss_v_r && !mac_vld))
    else $error("read pipeline not empty in idle");

  // end of a compute coincides with its final word
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last))
    else $error("busy dropped without final word");

endmodule
